### hw/rtl/dkpf_pkg.sv
// dkpf_pkg: shared types, constants and states of the 4-mer profile filter.
// Used by all modules under hw/rtl; no dependencies.
`timescale 1ns / 1ps
package dkpf_pkg;
    localparam int TABLE_ENTRIES = 256;
    localparam int COUNT_BITS = 16;
    localparam logic [1:0] CODE_MASK = 2'h3;
    localparam logic [7:0] CELL_MAX = 8'd255;

    // Request function codes.
    localparam logic FN_CHAR = 1'b0;
    localparam logic FN_CMP  = 1'b1;

    typedef struct packed {
        logic        func;
        logic        bank;
        logic [7:0]  symbol;
        logic        last;
        logic [15:0] ref_len;
        logic [15:0] lcs_min;
    } t_req;

    typedef struct packed {
        logic [15:0] word_count;
        logic [15:0] overflow_count;
        logic [16:0] shared_count;
        logic [15:0] needed_count;
        logic        pass;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_CLEAR, ST_BUMP, ST_SCAN, ST_BOUND, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        BD_IDLE, BD_DIV, BD_MUL, BD_OUT
    } t_bnd_state;

    // Request to the bound unit and its answer.
    typedef struct packed {
        logic        start;
        logic [15:0] ref_len;
        logic [15:0] lcs_min;
    } t_bnd_req;

    typedef struct packed {
        logic        done;
        logic [15:0] needed;
    } t_bnd_rsp;
endpackage

### hw/rtl/dna_4mer_profile_filter.sv
// dna_4mer_profile_filter: top level, sequencer around the count memory.
// Depends on dkpf_pkg, dkpf_table, dkpf_bound.
`timescale 1ns / 1ps
// After reset the block clears both count banks, one entry a cycle, and holds
// busy high while it does. A character that continues a sequence keeps busy
// high through a memory read and then a modify and write back, so a new
// character is not taken until the last one is through; the first character of a
// sequence first clears its bank entry by entry, and a character marked last
// also passes through the done state. A compare walks both banks through the single read
// port, alternating banks entry by entry, then runs the bound unit (a 16-bit
// shift-subtract division, then multiply and hand-over), all with busy high.
// Each result is strobed for one cycle on
// o_valid, in the first cycle with busy low; the receiver cannot stall, so
// busy is the only flow control.
module dna_4mer_profile_filter #(
    parameter int TABLE_ENTRIES = dkpf_pkg::TABLE_ENTRIES,
    parameter int COUNT_BITS    = dkpf_pkg::COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dkpf_pkg::t_req    i_req,
    output logic              o_valid,
    output dkpf_pkg::t_rsp    o_rsp
);
    localparam int AW = $clog2(2 * TABLE_ENTRIES);
    localparam int IW = AW - 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [AW:0] SCAN_END = (AW+1)'(2 * TABLE_ENTRIES);

    dkpf_pkg::t_state r_state, n_state;
    dkpf_pkg::t_req   r_req;
    logic [5:0] r_hist;
    logic [1:0] r_seen;
    logic       r_inseq;
    logic [COUNT_BITS-1:0] r_words [2];
    logic [COUNT_BITS-1:0] r_ovf [2];
    logic [AW:0] r_idx;
    logic        r_phase;
    logic [7:0]  r_hold;
    logic [16:0] r_sum;
    logic        r_bnd_go;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    dkpf_pkg::t_bnd_req bnd_req;
    dkpf_pkg::t_bnd_rsp bnd_rsp;

    logic [7:0] word;
    logic [AW-1:0] slot;
    assign word = {r_hist, (r_req.symbol[2:1] & dkpf_pkg::CODE_MASK)};
    assign slot = {r_req.bank, word[IW-1:0]};

    dkpf_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign bnd_req.start   = r_bnd_go;
    assign bnd_req.ref_len = r_req.ref_len;
    assign bnd_req.lcs_min = r_req.lcs_min;
    dkpf_bound u_bound (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(bnd_req), .o_rsp(bnd_rsp));

    assign busy = (r_state != dkpf_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        we      = 1'b0;
        waddr   = slot;
        wdata   = rdata + 8'd1;
        raddr   = slot;
        case (r_state)
            dkpf_pkg::ST_INIT: begin
                // zero both banks once after reset
                we    = 1'b1;
                waddr = r_idx[AW-1:0];
                wdata = '0;
                if (r_idx[AW-1:0] == {AW{1'b1}}) n_state = dkpf_pkg::ST_IDLE;
            end
            dkpf_pkg::ST_IDLE: if (start) begin
                if (i_req.func == dkpf_pkg::FN_CMP) n_state = dkpf_pkg::ST_SCAN;
                else if (!r_inseq) n_state = dkpf_pkg::ST_CLEAR;
                else n_state = dkpf_pkg::ST_BUMP;
            end
            dkpf_pkg::ST_CLEAR: begin
                we    = 1'b1;
                waddr = {r_req.bank, r_idx[IW-1:0]};
                wdata = '0;
                if (r_idx[IW-1:0] == {IW{1'b1}}) n_state = dkpf_pkg::ST_BUMP;
            end
            dkpf_pkg::ST_BUMP: begin
                // phase 0 reads the entry, phase 1 writes back
                if (r_phase) begin
                    we = (r_seen == 2'd3) && (rdata != dkpf_pkg::CELL_MAX);
                    n_state = r_req.last ? dkpf_pkg::ST_DONE : dkpf_pkg::ST_IDLE;
                end
            end
            dkpf_pkg::ST_SCAN: begin
                // even steps read bank 0, odd steps the same entry of bank 1
                raddr = {r_idx[0], r_idx[IW:1]};
                if (r_idx == SCAN_END) n_state = dkpf_pkg::ST_BOUND;
            end
            dkpf_pkg::ST_BOUND: if (bnd_rsp.done) n_state = dkpf_pkg::ST_DONE;
            dkpf_pkg::ST_DONE: n_state = dkpf_pkg::ST_IDLE;
            default: n_state = dkpf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= dkpf_pkg::ST_INIT;
        else          r_state <= n_state;
    end

    logic [7:0] mn;
    logic [COUNT_BITS-1:0] ovmin;
    logic [31:0] shared_full;
    logic [16:0] fin_sum;
    assign mn = (r_hold < rdata) ? r_hold : rdata;
    assign ovmin = (r_ovf[0] < r_ovf[1]) ? r_ovf[0] : r_ovf[1];
    assign shared_full = 32'(r_sum) + 32'(ovmin);
    assign fin_sum = shared_full[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0; r_seen <= '0; r_inseq <= 1'b0;
            r_words[0] <= '0; r_words[1] <= '0;
            r_ovf[0] <= '0; r_ovf[1] <= '0;
            r_idx <= '0;
            r_phase <= 1'b0; r_bnd_go <= 1'b0; o_valid <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_bnd_go <= 1'b0;
            case (r_state)
                dkpf_pkg::ST_INIT: r_idx <= r_idx + (AW+1)'(1);
                dkpf_pkg::ST_IDLE: if (start) begin
                    r_req <= i_req; r_idx <= '0; r_phase <= 1'b0; r_sum <= '0;
                    if (i_req.func == dkpf_pkg::FN_CHAR && !r_inseq) begin
                        r_words[i_req.bank] <= '0; r_ovf[i_req.bank] <= '0;
                        r_hist <= '0; r_seen <= '0; r_inseq <= 1'b1;
                    end
                end
                dkpf_pkg::ST_CLEAR: r_idx <= r_idx + (AW+1)'(1);
                dkpf_pkg::ST_BUMP: begin
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        if (r_seen == 2'd3) begin
                            if (rdata == dkpf_pkg::CELL_MAX && r_ovf[r_req.bank] != CMAX)
                                r_ovf[r_req.bank] <= r_ovf[r_req.bank] + COUNT_BITS'(1);
                            if (r_words[r_req.bank] != CMAX)
                                r_words[r_req.bank] <= r_words[r_req.bank] + COUNT_BITS'(1);
                        end else r_seen <= r_seen + 2'd1;
                        r_hist <= word[5:0];
                        if (r_req.last) r_inseq <= 1'b0;
                    end
                end
                dkpf_pkg::ST_SCAN: begin
                    // data returns in the cycle after its read: hold bank 0, add the minimum
                    r_idx <= r_idx + (AW+1)'(1);
                    if (r_idx[0])
                        r_hold <= rdata;
                    else if (r_idx != '0)
                        r_sum <= r_sum + 17'(mn);
                    if (r_idx == SCAN_END) r_bnd_go <= 1'b1;
                end
                default: ;
            endcase
            if (r_state == dkpf_pkg::ST_DONE) o_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == dkpf_pkg::ST_DONE) begin
            if (r_req.func == dkpf_pkg::FN_CMP) begin
                o_rsp.word_count     <= '0;
                o_rsp.overflow_count <= '0;
                o_rsp.shared_count   <= fin_sum;
                if (r_req.lcs_min <= r_req.ref_len) begin
                    o_rsp.needed_count <= bnd_rsp.needed;
                    o_rsp.pass <= (shared_full >= 32'(bnd_rsp.needed));
                end else begin
                    o_rsp.needed_count <= '0;
                    o_rsp.pass <= 1'b0;
                end
            end else begin
                o_rsp.word_count     <= 16'(r_words[r_req.bank]);
                o_rsp.overflow_count <= 16'(r_ovf[r_req.bank]);
                o_rsp.shared_count   <= '0;
                o_rsp.needed_count   <= '0;
                o_rsp.pass           <= 1'b0;
            end
        end
    end

    a_no_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dkpf_pkg::ST_SCAN) |-> !we) else $error("write during scan");
    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dkpf_pkg::ST_DONE) |=> o_valid) else $error("lost result");
    a_busy_on_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without request");
endmodule

### hw/rtl/dkpf_bound.sv
// dkpf_bound: integer LCS word bound, with a shift-subtract divider.
// Depends on dkpf_pkg.
`timescale 1ns / 1ps
module dkpf_bound (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dkpf_pkg::t_bnd_req i_req,
    output dkpf_pkg::t_bnd_rsp o_rsp
);
    dkpf_pkg::t_bnd_state r_st, n_st;
    logic [4:0]  r_cnt;
    logic [16:0] r_frags;
    logic [15:0] r_quo;
    logic [17:0] r_rem;
    logic [15:0] r_lcs;
    logic [33:0] r_pa, r_pb;
    logic [15:0] r_need;
    logic [17:0] n_rem;
    logic [15:0] s_a, s_b;
    logic [16:0] s_fr;
    logic [34:0] s_sum;

    assign n_rem = {r_rem[16:0], r_lcs[15]};
    assign s_a   = (r_quo > 16'd2) ? r_quo - 16'd2 : 16'd0;
    assign s_b   = (r_quo > 16'd3) ? r_quo - 16'd3 : 16'd0;
    assign s_fr  = r_frags - r_rem[16:0];
    assign s_sum = {1'b0, r_pa} + {1'b0, r_pb};

    always_comb begin
        n_st = r_st;
        case (r_st)
            dkpf_pkg::BD_IDLE: if (i_req.start) n_st = dkpf_pkg::BD_DIV;
            dkpf_pkg::BD_DIV:  if (r_cnt == 5'd1) n_st = dkpf_pkg::BD_MUL;
            dkpf_pkg::BD_MUL:  n_st = dkpf_pkg::BD_OUT;
            dkpf_pkg::BD_OUT:  n_st = dkpf_pkg::BD_IDLE;
            default: n_st = dkpf_pkg::BD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= dkpf_pkg::BD_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            dkpf_pkg::BD_IDLE: if (i_req.start) begin
                r_frags <= {i_req.ref_len - i_req.lcs_min, 1'b1};
                r_lcs   <= i_req.lcs_min;
                r_rem   <= '0;
                r_quo   <= '0;
                r_cnt   <= 5'd16;
            end
            dkpf_pkg::BD_DIV: begin
                // one quotient bit per cycle
                r_lcs <= {r_lcs[14:0], 1'b0};
                if (n_rem >= {1'b0, r_frags}) begin
                    r_rem <= n_rem - {1'b0, r_frags};
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
            end
            dkpf_pkg::BD_MUL: begin
                r_pa <= {1'b0, s_a} * r_rem[16:0];
                r_pb <= {1'b0, s_b} * s_fr;
            end
            dkpf_pkg::BD_OUT: begin
                r_need <= (s_sum > 35'hFFFF) ? 16'hFFFF : s_sum[15:0];
            end
            default: ;
        endcase
    end

    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= (r_st == dkpf_pkg::BD_OUT);
    end
    assign o_rsp.done   = r_done;
    assign o_rsp.needed = r_need;
endmodule

### hw/rtl/dkpf_table.sv
// dkpf_table: 512 x 8 count memory, one write and one registered read port.
// Depends on dkpf_pkg.
`timescale 1ns / 1ps
module dkpf_table #(
    parameter int ENTRIES = dkpf_pkg::TABLE_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(2*ENTRIES)-1:0] i_waddr,
    input  logic [7:0]                   i_wdata,
    input  logic [$clog2(2*ENTRIES)-1:0] i_raddr,
    output logic [7:0]                   o_rdata
);
    logic [7:0] r_mem [2*ENTRIES];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
